FILE: design/dvbp_pkg.sv
// ----------------------------------------------------------------------------
// dvbp_pkg: shared types and helpers for the delta varint block packer
// Item, result and internal op formats, varint length and byte encoding.
// ----------------------------------------------------------------------------
package dvbp_pkg;

	// Default block size in bytes and header length
	localparam int BLOCK_BYTES_DEF = 128;
	localparam int HEAD_LEN        = 2;

	// Depths of the op queue and the result queue
	localparam int OP_QUEUE_DEPTH  = 4;
	localparam int OUT_QUEUE_DEPTH = 4;

	// Input item
	typedef struct packed {
		logic        command;
		logic [31:0] key;
		logic [31:0] value;
	} in_t;

	// Command codes
	localparam logic CMD_APPEND = 1'b0;
	localparam logic CMD_FLUSH  = 1'b1;

	// Result item: one block word
	typedef struct packed {
		logic [63:0] block_word;
		logic [3:0]  word_index;
		logic [31:0] block_first_key;
		logic        last_word;
	} out_t;

	// Per-block data handed to the emitter
	typedef struct packed {
		logic [15:0] count;
		logic [31:0] lead_key;
	} info_t;

	// Op from the front to the back: optionally close the open block,
	// then write nvar varints (v0, then v1)
	typedef struct packed {
		logic        close;
		info_t       info;
		logic [1:0]  nvar;
		logic [31:0] v0;
		logic [31:0] v1;
	} op_t;

	// Number of bytes of a 32-bit varint
	function automatic logic [2:0] varint_len(input logic [31:0] v);
		logic [2:0] n;
		if (v < 32'h0000_0080) begin
			n = 3'd1;
		end else if (v < 32'h0000_4000) begin
			n = 3'd2;
		end else if (v < 32'h0020_0000) begin
			n = 3'd3;
		end else if (v < 32'h1000_0000) begin
			n = 3'd4;
		end else begin
			n = 3'd5;
		end
		return n;
	endfunction

	// Varint bytes, most significant group first, left aligned in 40 bits
	function automatic logic [39:0] varint_bytes(input logic [31:0] v);
		logic [39:0] b;
		case (varint_len(v))
			3'd1:    b = {1'b0, v[6:0], 32'b0};
			3'd2:    b = {1'b1, v[13:7], 1'b0, v[6:0], 24'b0};
			3'd3:    b = {1'b1, v[20:14], 1'b1, v[13:7], 1'b0, v[6:0], 16'b0};
			3'd4:    b = {1'b1, v[27:21], 1'b1, v[20:14], 1'b1, v[13:7],
				1'b0, v[6:0], 8'b0};
			default: b = {1'b1, 3'b000, v[31:28], 1'b1, v[27:21], 1'b1, v[20:14],
				1'b1, v[13:7], 1'b0, v[6:0]};
		endcase
		return b;
	endfunction

endpackage

FILE: design/dvbp_fifo.sv
// ----------------------------------------------------------------------------
// dvbp_fifo: small synchronous queue
// Flip-flop storage, push/full on the write side, pop/empty on the read side.
// ----------------------------------------------------------------------------
module dvbp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	output logic                       full,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rdata   = store_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// Write the entry at the tail
	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/dvbp_front.sv
// ----------------------------------------------------------------------------
// dvbp_front: item intake and classification
// Tracks key/value history and block fill, computes deltas and the fit check,
// and turns each item into an op for the back part (a flush with no open block yields none).
// ----------------------------------------------------------------------------
module dvbp_front import dvbp_pkg::*; #(
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  in_t  item,
	output logic op_push,
	output op_t  op_wdata,
	input  logic op_full
);

	localparam int FILL_W = $clog2(BLOCK_BYTES + 1);
	localparam int CNT_W  = $clog2(BLOCK_BYTES);

	logic              open_q;
	logic [31:0]       prev_key_q;
	logic [31:0]       prev_value_q;
	logic [31:0]       lead_key_q;
	logic [FILL_W-1:0] fill_q;
	logic [CNT_W-1:0]  count_q;

	logic              accept;
	logic [31:0]       key_step;
	logic [31:0]       value_step;
	logic [2:0]        key_len;
	logic [2:0]        value_len;
	logic [2:0]        first_len;
	logic [FILL_W:0]   pair_end;
	logic              fits;

	assign full   = op_full;
	assign accept = push && !op_full;

	// Deltas; the value delta restarts when the key changes
	assign key_step   = item.key - prev_key_q;
	assign value_step = item.value - ((prev_key_q == item.key) ? prev_value_q : 32'd0);
	assign key_len    = varint_len(key_step);
	assign value_len  = varint_len(value_step);
	assign first_len  = varint_len(item.value);
	assign pair_end   = {1'b0, fill_q} + (FILL_W + 1)'(key_len) + (FILL_W + 1)'(value_len);
	assign fits       = pair_end <= (FILL_W + 1)'(BLOCK_BYTES);

	// Build the op for this item
	always_comb begin
		op_push                = 1'b0;
		op_wdata.close         = 1'b0;
		op_wdata.info.count    = 16'(count_q);
		op_wdata.info.lead_key = lead_key_q;
		op_wdata.nvar          = 2'd1;
		op_wdata.v0            = item.value;
		op_wdata.v1            = value_step;
		if (accept) begin
			if (item.command == CMD_FLUSH) begin
				op_push        = open_q;
				op_wdata.close = 1'b1;
				op_wdata.nvar  = 2'd0;
			end else begin
				op_push = 1'b1;
				if (open_q) begin
					if (fits) begin
						op_wdata.nvar = 2'd2;
						op_wdata.v0   = key_step;
					end else begin
						op_wdata.close = 1'b1;
					end
				end
			end
		end
	end

	// Update history, fill and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q       <= 1'b0;
			prev_key_q   <= '0;
			prev_value_q <= '0;
			lead_key_q   <= '0;
			fill_q       <= FILL_W'(HEAD_LEN);
			count_q      <= '0;
		end else if (accept) begin
			if (item.command == CMD_FLUSH) begin
				open_q <= 1'b0;
			end else begin
				open_q       <= 1'b1;
				prev_key_q   <= item.key;
				prev_value_q <= item.value;
				if (open_q && fits) begin
					fill_q  <= pair_end[FILL_W-1:0];
					count_q <= count_q + 1'b1;
				end else begin
					// open a block with this entry first
					fill_q     <= FILL_W'(HEAD_LEN) + FILL_W'(first_len);
					count_q    <= CNT_W'(1);
					lead_key_q <= item.key;
				end
			end
		end
	end

endmodule

FILE: design/dvbp_back.sv
// ----------------------------------------------------------------------------
// dvbp_back: block assembly
// Executes ops: closes blocks toward the emitter and packs varint bytes into
// a word accumulator, writing each completed word to the block memory.
// ----------------------------------------------------------------------------
module dvbp_back import dvbp_pkg::*; #(
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  op_t                                       op,
	input  logic                                      op_empty,
	output logic                                      op_pop,
	input  logic                                      busy,
	output logic                                      start,
	output logic                                      start_bank,
	output logic [$clog2(BLOCK_BYTES+1)-1:0]          start_fill,
	output info_t                                     start_info,
	output logic                                      wr_en,
	output logic [$clog2((BLOCK_BYTES+7)/8):0]        wr_addr,
	output logic [63:0]                               wr_data
);

	localparam int FILL_W = $clog2(BLOCK_BYTES + 1);
	localparam int WORDS  = (BLOCK_BYTES + 7) / 8;
	localparam int WIDX_W = $clog2(WORDS);

	logic              bank_q;
	logic [FILL_W-1:0] fill_q;
	logic [63:0]       cur_q;
	logic              closed_q;
	logic              vsel_q;

	logic              head;
	logic              do_close;
	logic              close_go;
	logic              do_var;
	logic              last_var;
	logic [31:0]       var_value;
	logic [2:0]        var_len;
	logic [127:0]      shifted;
	logic [127:0]      merged;
	logic [3:0]        byte_end;
	logic              spill;
	logic [WIDX_W-1:0] word_sel;

	assign head      = !op_empty;
	assign do_close  = head && op.close && !closed_q;
	assign close_go  = do_close && !busy;
	assign do_var    = head && !do_close;
	assign last_var  = ((vsel_q ? 2'd2 : 2'd1) == op.nvar);
	assign var_value = vsel_q ? op.v1 : op.v0;
	assign var_len   = varint_len(var_value);

	// Align the varint bytes behind the bytes already in the accumulator
	assign shifted  = {varint_bytes(var_value), 88'b0} >> {fill_q[2:0], 3'b000};
	assign merged   = {cur_q, 64'b0} | shifted;
	assign byte_end = {1'b0, fill_q[2:0]} + {1'b0, var_len};
	assign spill    = byte_end[3];
	assign word_sel = WIDX_W'(fill_q >> 3);

	// Hand the closed block to the emitter
	assign start      = close_go;
	assign start_bank = bank_q;
	assign start_fill = fill_q;
	assign start_info = op.info;

	// Memory write: partial word on close, full word on spill
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = {bank_q, word_sel};
		wr_data = cur_q;
		if (close_go) begin
			wr_en = (fill_q[2:0] != 3'b000);
		end else if (do_var) begin
			wr_en   = spill;
			wr_data = merged[127:64];
		end
	end

	assign op_pop = (close_go && (op.nvar == 2'd0)) || (do_var && last_var);

	// Advance assembly state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q   <= 1'b0;
			fill_q   <= FILL_W'(HEAD_LEN);
			cur_q    <= '0;
			closed_q <= 1'b0;
			vsel_q   <= 1'b0;
		end else if (close_go) begin
			bank_q   <= !bank_q;
			fill_q   <= FILL_W'(HEAD_LEN);
			cur_q    <= '0;
			closed_q <= (op.nvar != 2'd0);
		end else if (do_var) begin
			fill_q <= fill_q + FILL_W'(var_len);
			cur_q  <= spill ? merged[63:0] : merged[127:64];
			if (last_var) begin
				vsel_q   <= 1'b0;
				closed_q <= 1'b0;
			end else begin
				vsel_q <= 1'b1;
			end
		end
	end

endmodule

FILE: design/dvbp_emit.sv
// ----------------------------------------------------------------------------
// dvbp_emit: block memory and word emitter
// Holds two banks of block words; reads a closed block out one word per cycle
// while the result queue has room, inserting the entry count header.
// ----------------------------------------------------------------------------
module dvbp_emit import dvbp_pkg::*; #(
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [$clog2((BLOCK_BYTES+7)/8):0]   wr_addr,
	input  logic [63:0]                          wr_data,
	input  logic                                 start,
	input  logic                                 start_bank,
	input  logic [$clog2(BLOCK_BYTES+1)-1:0]     start_fill,
	input  info_t                                start_info,
	output logic                                 busy,
	input  logic                                 pop,
	output logic                                 empty,
	output out_t                                 result
);

	localparam int FILL_W  = $clog2(BLOCK_BYTES + 1);
	localparam int WORDS   = (BLOCK_BYTES + 7) / 8;
	localparam int WIDX_W  = $clog2(WORDS);
	localparam int MEM_D   = 2 << WIDX_W;
	localparam int OCNT_W  = $clog2(OUT_QUEUE_DEPTH + 1);

	logic [63:0]       mem [MEM_D];

	logic              active_q;
	logic              bank_q;
	logic [WIDX_W-1:0] idx_q;
	logic [FILL_W-1:0] fill_e_q;
	info_t             info_q;

	logic              rd_valid_s1;
	logic [WIDX_W-1:0] rd_idx_s1;
	logic [63:0]       rdata_s1;

	logic [OCNT_W-1:0] ofifo_count;
	logic              ofifo_full;
	logic [OCNT_W:0]   pending;
	logic              issue;
	logic              has_data;
	out_t              word_out;

	assign busy    = active_q;
	assign pending = {1'b0, ofifo_count} + (OCNT_W + 1)'(rd_valid_s1);
	assign issue   = active_q && (pending < (OCNT_W + 1)'(OUT_QUEUE_DEPTH));

	// Write completed words
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read the next word of the closed block
	always_ff @(posedge clk) begin
		if (issue) begin
			rdata_s1 <= mem[{bank_q, idx_q}];
		end
	end

	// Sequence the read-out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			bank_q      <= 1'b0;
			idx_q       <= '0;
			rd_valid_s1 <= 1'b0;
			rd_idx_s1   <= '0;
		end else begin
			rd_valid_s1 <= issue;
			if (issue) begin
				rd_idx_s1 <= idx_q;
			end
			if (start) begin
				active_q <= 1'b1;
				bank_q   <= start_bank;
				idx_q    <= '0;
			end else if (issue) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == WIDX_W'(WORDS - 1)) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	// Hold block data for the read-out
	always_ff @(posedge clk) begin
		if (start) begin
			fill_e_q <= start_fill;
			info_q   <= start_info;
		end
	end

	// Compose the result word: unwritten words read as zero, header on word 0
	assign has_data = (FILL_W + 3)'({rd_idx_s1, 3'b000}) < (FILL_W + 3)'(fill_e_q);

	always_comb begin
		word_out.block_word      = has_data ? rdata_s1 : 64'b0;
		if (rd_idx_s1 == '0) begin
			word_out.block_word[63:48] = info_q.count;
		end
		word_out.word_index      = 4'(rd_idx_s1);
		word_out.block_first_key = info_q.lead_key;
		word_out.last_word       = (rd_idx_s1 == WIDX_W'(WORDS - 1));
	end

	dvbp_fifo #(
		.WIDTH ($bits(out_t)),
		.DEPTH (OUT_QUEUE_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rd_valid_s1),
		.wdata  (word_out),
		.full   (ofifo_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty),
		.count  (ofifo_count)
	);

`ifndef ASSERT_OFF
	// A new block never arrives while the previous one is still being read
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !active_q)
		else $error("block handed over while read-out active");

	// Read credit keeps the result queue from overflowing
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> !ofifo_full)
		else $error("result queue overflow");

	// Read-out ends after the last word is issued
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		issue && !start && (idx_q == WIDX_W'(WORDS - 1)) |=> !active_q)
		else $error("read-out did not end after last word");
`endif

endmodule

FILE: design/delta_varint_block_packer.sv
// ----------------------------------------------------------------------------
// delta_varint_block_packer: sorted key/value pairs into fixed varint blocks
// A front part classifies each item into an op, a short op queue decouples it
// from the back part that packs varint bytes into a two-bank block memory,
// and an emitter streams each closed block out as 64-bit words.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-------------------------------
//   item     | in        | push / full        | command, key, value
//   result   | out       | empty / pop        | block_word, word_index,
//            |           |                    | block_first_key, last_word
//
// The front takes one item per cycle while the op queue has room.
// The back packs varints one at a time: one for a block's first entry,
// two for a delta pair; each block close is a separate step.
// A block goes out as (BLOCK_BYTES+7)/8 words, one per cycle while the result
// queue has room; a close waits until the previous read-out has been issued.
// Reset clears control state only; the block memory needs no clearing pass.
// ----------------------------------------------------------------------------
module delta_varint_block_packer import dvbp_pkg::*; #(
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  in_t  item,
	output logic empty,
	input  logic pop,
	output out_t result
);

	localparam int FILL_W = $clog2(BLOCK_BYTES + 1);
	localparam int WORDS  = (BLOCK_BYTES + 7) / 8;
	localparam int WIDX_W = $clog2(WORDS);

	logic                               op_push;
	op_t                                op_wdata;
	logic                               op_full;
	op_t                                op_head;
	logic                               op_empty;
	logic                               op_pop;
	logic [$clog2(OP_QUEUE_DEPTH+1)-1:0] op_count;

	logic              busy;
	logic              start;
	logic              start_bank;
	logic [FILL_W-1:0] start_fill;
	info_t             start_info;
	logic              wr_en;
	logic [WIDX_W:0]   wr_addr;
	logic [63:0]       wr_data;

	dvbp_front #(
		.BLOCK_BYTES (BLOCK_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.op_push  (op_push),
		.op_wdata (op_wdata),
		.op_full  (op_full)
	);

	dvbp_fifo #(
		.WIDTH ($bits(op_t)),
		.DEPTH (OP_QUEUE_DEPTH)
	) u_op_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (op_push),
		.wdata  (op_wdata),
		.full   (op_full),
		.pop    (op_pop),
		.rdata  (op_head),
		.empty  (op_empty),
		.count  (op_count)
	);

	dvbp_back #(
		.BLOCK_BYTES (BLOCK_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op_head),
		.op_empty   (op_empty),
		.op_pop     (op_pop),
		.busy       (busy),
		.start      (start),
		.start_bank (start_bank),
		.start_fill (start_fill),
		.start_info (start_info),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data)
	);

	dvbp_emit #(
		.BLOCK_BYTES (BLOCK_BYTES)
	) u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.start      (start),
		.start_bank (start_bank),
		.start_fill (start_fill),
		.start_info (start_info),
		.busy       (busy),
		.pop        (pop),
		.empty      (empty),
		.result     (result)
	);

`ifndef ASSERT_OFF
	// Op queue occupancy stays within its depth
	a_op_count: assert property (@(posedge clk) disable iff (!arst_n)
		op_count <= ($clog2(OP_QUEUE_DEPTH+1))'(OP_QUEUE_DEPTH))
		else $error("op queue occupancy out of range");
`endif

endmodule

FILE: tb/sv/block_word_checker.sv
// ----------------------------------------------------------------------------
// block_word_checker: predicts and checks the block words of the packer
// Watches the item and result channels of delta_varint_block_packer. Each
// accepted item transaction runs through a local copy of the packing state,
// and the block words it closes are queued. Each accepted result transaction
// is compared field by field with the oldest queued word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_word_checker import dvbp_pkg::*; #(
	parameter int BLOCK_LEN = BLOCK_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic full,
	input  in_t  item,
	input  logic empty,
	input  logic pop,
	input  out_t result,
	output int   fail_count,
	output int   outstanding
);

	localparam int WORDS_PER_BLOCK = (BLOCK_LEN + 7) / 8;

	// Local packing state
	logic [7:0]  block_image [BLOCK_LEN];
	int unsigned fill_pos;
	int unsigned entries;
	logic [31:0] prev_key;
	logic [31:0] prev_value;
	logic [31:0] lead_key;
	bit          is_open;

	// Block words still to come out of the packer, oldest first
	out_t expected_words [$];

	// Bytes needed for a 32-bit varint
	function automatic int unsigned varint_size(input logic [31:0] v);
		int unsigned n;
		n = 1;
		for (int s = 7; s < 32; s += 7) begin
			if ((v >> s) != 0) begin
				n++;
			end
		end
		return n;
	endfunction

	// Append one varint, most significant group first
	task automatic write_varint(input logic [31:0] v);
		int unsigned n;
		logic [7:0] b;
		n = varint_size(v);
		for (int unsigned i = 0; i < n; i++) begin
			b = 8'((v >> (7 * (n - 1 - i))) & 32'h7f);
			if (i + 1 < n) begin
				b[7] = 1'b1;
			end
			if (fill_pos < BLOCK_LEN) begin
				block_image[fill_pos] = b;
			end
			fill_pos++;
		end
	endtask

	task automatic start_block(input logic [31:0] k);
		foreach (block_image[i]) begin
			block_image[i] = 8'h00;
		end
		fill_pos   = HEAD_LEN;
		entries    = 0;
		prev_key   = k;
		prev_value = '0;
		lead_key   = k;
		is_open    = 1'b1;
	endtask

	// Write the entry count and queue every word of the block
	task automatic close_block();
		out_t w;
		int unsigned pos;
		block_image[0] = 8'((entries >> 8) & 8'hff);
		block_image[1] = 8'(entries & 8'hff);
		for (int unsigned i = 0; i < WORDS_PER_BLOCK; i++) begin
			w = '0;
			for (int unsigned j = 0; j < 8; j++) begin
				pos = i * 8 + j;
				w.block_word = {w.block_word[55:0],
					(pos < BLOCK_LEN) ? block_image[pos] : 8'h00};
			end
			w.word_index      = 4'(i);
			w.block_first_key = lead_key;
			w.last_word       = (i + 1 == WORDS_PER_BLOCK);
			expected_words.push_back(w);
		end
	endtask

	// Advance the packing state by one item transaction
	task automatic pack_item(input in_t it);
		logic [31:0] kd;
		logic [31:0] vd;
		if (it.command == CMD_FLUSH) begin
			if (is_open) begin
				close_block();
				is_open = 1'b0;
			end
		end else begin
			if (!is_open) begin
				start_block(it.key);
			end
			if (prev_key != it.key) begin
				prev_value = '0;
			end
			kd = it.key - prev_key;
			vd = it.value - prev_value;
			if (entries == 0) begin
				write_varint(vd);
				entries++;
			end else if (fill_pos + varint_size(kd) + varint_size(vd) <= BLOCK_LEN) begin
				write_varint(kd);
				write_varint(vd);
				entries++;
			end else begin
				// entry does not fit: ship the block, reopen with this entry
				close_block();
				start_block(it.key);
				write_varint(it.value);
				entries++;
			end
			prev_key   = it.key;
			prev_value = it.value;
		end
	endtask

	initial begin
		fail_count  = 0;
		outstanding = 0;
		foreach (block_image[i]) begin
			block_image[i] = 8'h00;
		end
		fill_pos   = HEAD_LEN;
		entries    = 0;
		prev_key   = '0;
		prev_value = '0;
		lead_key   = '0;
		is_open    = 1'b0;
	end

	// Check result transactions, then predict from item transactions
	always @(posedge clk) begin
		out_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected block word %h (index %0d)",
						$time, result.block_word, result.word_index);
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					if (result.block_word !== want.block_word) begin
						$display("%0t: block_word expected %h, got %h",
							$time, want.block_word, result.block_word);
						fail_count++;
					end
					if (result.word_index !== want.word_index) begin
						$display("%0t: word_index expected %0d, got %0d",
							$time, want.word_index, result.word_index);
						fail_count++;
					end
					if (result.block_first_key !== want.block_first_key) begin
						$display("%0t: block_first_key expected %h, got %h",
							$time, want.block_first_key, result.block_first_key);
						fail_count++;
					end
					if (result.last_word !== want.last_word) begin
						$display("%0t: last_word expected %b, got %b",
							$time, want.last_word, result.last_word);
						fail_count++;
					end
				end
			end
			if (push && !full) begin
				pack_item(item);
			end
			outstanding = expected_words.size();
		end
	end

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for delta_varint_block_packer
// Sends a directed set of items covering field extremes, key changes, wrapping
// deltas, overflowing blocks and flushes, then sorted runs with random deltas
// mixed with noise, under random idling and one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import dvbp_pkg::*;

	localparam int RANDOM_ITEMS = 360;
	localparam int HOLD_AT_ITEM = 100;
	localparam int HOLD_CYCLES  = 600;
	localparam int CALM_CYCLES  = 500;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	in_t  item;
	logic empty;
	logic pop;
	out_t result;
	int   fail_count;
	int   outstanding;
	int   items_sent;

	delta_varint_block_packer #(.BLOCK_BYTES(BLOCK_BYTES_DEF)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	block_word_checker #(.BLOCK_LEN(BLOCK_BYTES_DEF)) words_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.item        (item),
		.empty       (empty),
		.pop         (pop),
		.result      (result),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// 20 ns clock
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic in_t make_item(input logic cmd, input logic [31:0] k,
		input logic [31:0] v);
		in_t it;
		it.command = cmd;
		it.key     = k;
		it.value   = v;
		return it;
	endfunction

	// Random delta whose varint is mostly short, sometimes up to five bytes
	function automatic logic [31:0] random_delta();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return $urandom_range(0, 127);
		end else if (r < 75) begin
			return $urandom_range(128, 16383);
		end else if (r < 87) begin
			return $urandom_range(16384, 2097151);
		end else if (r < 95) begin
			return $urandom_range(2097152, 268435455);
		end
		return $urandom_range(268435456, 32'hffff_ffff);
	endfunction

	// Offer one item transaction, idling at random outside the calm stretch
	task automatic offer_item(input in_t it);
		bit calm;
		calm = (items_sent >= 200 && items_sent < 280);
		while (!calm && $urandom_range(0, 99) < 10) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		items_sent++;
	endtask

	// Receiver: random stalls, one long hold-off, then a stretch of steady pops
	initial begin
		int hold_left;
		int calm_left;
		bit hold_done;
		hold_left = 0;
		calm_left = 0;
		hold_done = 1'b0;
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				calm_left = CALM_CYCLES;
				pop <= 1'b0;
			end else if (calm_left > 0) begin
				pop <= 1'b1;
				calm_left--;
			end else begin
				pop <= ($urandom_range(0, 99) >= 10);
			end
		end
	end

	// Stimulus and verdict
	initial begin
		logic [31:0] k;
		logic [31:0] v;
		int run_len;
		push       = 1'b0;
		item       = '0;
		items_sent = 0;
		arst_n     = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: flush with nothing open, first entry, same key, key change
		offer_item(make_item(CMD_FLUSH, 32'h0, 32'h0));
		offer_item(make_item(CMD_APPEND, 32'h0, 32'h0));
		offer_item(make_item(CMD_APPEND, 32'h0, 32'h7f));
		offer_item(make_item(CMD_APPEND, 32'h0, 32'h80));
		offer_item(make_item(CMD_APPEND, 32'h1, 32'hffff_ffff));
		offer_item(make_item(CMD_APPEND, 32'h1, 32'hffff_ffff));
		// key going down wraps the delta
		offer_item(make_item(CMD_APPEND, 32'h0, 32'h5));
		offer_item(make_item(CMD_APPEND, 32'hffff_ffff, 32'h0));
		offer_item(make_item(CMD_FLUSH, 32'hffff_ffff, 32'hffff_ffff));
		offer_item(make_item(CMD_FLUSH, 32'h0, 32'h0));
		// five-byte deltas until an entry no longer fits
		for (int i = 0; i < 14; i++) begin
			offer_item(make_item(CMD_APPEND, 32'h0123_4567 + i * 32'h1000_0000,
				32'hf000_0000 + i));
		end
		offer_item(make_item(CMD_FLUSH, 32'h0, 32'h0));

		// random: sorted runs with random content, some noise in between
		k = $urandom();
		v = '0;
		while (items_sent < RANDOM_ITEMS + 25) begin
			if ($urandom_range(0, 99) < 10) begin
				offer_item(make_item(($urandom_range(0, 3) == 0) ? CMD_FLUSH : CMD_APPEND,
					$urandom(), $urandom()));
			end else begin
				if ($urandom_range(0, 1) == 0) begin
					k = $urandom();
					v = random_delta();
				end
				run_len = $urandom_range(5, 60);
				for (int j = 0; j < run_len; j++) begin
					if ($urandom_range(0, 99) < 40) begin
						v = v + random_delta();
					end else begin
						k = k + 32'(random_delta()) + 32'd1;
						v = random_delta();
					end
					offer_item(make_item(CMD_APPEND, k, v));
				end
				if ($urandom_range(0, 1) == 0) begin
					offer_item(make_item(CMD_FLUSH, $urandom(), $urandom()));
				end
			end
		end
		offer_item(make_item(CMD_FLUSH, 32'h0, 32'h0));
		push <= 1'b0;
		@(posedge clk);

		// drain, then keep watching for stray words
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Hang guard
	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
